### design/ils_pkg.sv
`default_nettype none

package ils_pkg;

    // Capacity of the list and the widths that follow from it
    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    // Fixed field widths of the item channels
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 3;
    localparam int POS_W       = 7;
    localparam int FPOS_W      = 6;
    localparam int COUNT_OUT_W = 7;

    // Common width for comparing an index against the count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd5;

    // Element memory access for one cycle
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } mem_req_t;

    // One result item
    typedef struct packed {
        logic                   ok;
        logic [DATA_W-1:0]      data;
        logic [FPOS_W-1:0]      fpos;
        logic [COUNT_OUT_W-1:0] count;
    } res_t;

endpackage

`default_nettype wire

### design/ils_ram.sv
`default_nettype none

module ils_ram (
    input  wire                        clk,
    input  wire ils_pkg::mem_req_t     req,
    output logic [ils_pkg::DATA_W-1:0] rd_data
);

    logic [ils_pkg::DATA_W-1:0] mem [ils_pkg::MAX_ELEMENTS];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/ils_ctrl.sv
`default_nettype none

module ils_ctrl (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [ils_pkg::MODE_W-1:0]   in_mode,
    input  wire  [ils_pkg::POS_W-1:0]    in_pos,
    input  wire  [ils_pkg::DATA_W-1:0]   in_value,
    output ils_pkg::mem_req_t            mem_req,
    input  wire  [ils_pkg::DATA_W-1:0]   mem_rdata,
    output logic                         res_valid,
    input  wire                          res_ready,
    output ils_pkg::res_t                res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Control state
    logic [1:0]                  state_reg, state_next;
    logic [ils_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        issue_reg, issue_next;
    logic                        pend_reg, pend_next;

    // Operation and result payload
    logic [ils_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [ils_pkg::IDX_W-1:0]   pos_reg, pos_next;
    logic [ils_pkg::DATA_W-1:0]  val_reg, val_next;
    logic [ils_pkg::IDX_W-1:0]   addr_reg, addr_next;
    logic [ils_pkg::IDX_W-1:0]   end_reg, end_next;
    logic [ils_pkg::IDX_W-1:0]   paddr_reg, paddr_next;
    logic                        plast_reg, plast_next;
    logic                        ok_reg, ok_next;
    logic [ils_pkg::DATA_W-1:0]  data_reg, data_next;
    logic [ils_pkg::IDX_W-1:0]   fpos_reg, fpos_next;

    logic                        accept;
    logic                        full;
    logic                        issue_last;
    logic                        rd_issue;
    logic [ils_pkg::CMP_W-1:0]   pos_cmp;
    logic [ils_pkg::CMP_W-1:0]   cnt_cmp;
    logic [ils_pkg::CNT_W-1:0]   count_dec;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign full       = (count_reg == ils_pkg::CNT_W'(ils_pkg::MAX_ELEMENTS));
    assign issue_last = (addr_reg == end_reg);
    assign pos_cmp    = ils_pkg::CMP_W'(in_pos);
    assign cnt_cmp    = ils_pkg::CMP_W'(count_reg);
    assign count_dec  = count_reg - 1'b1;

    // Sequence the memory accesses of one operation
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        issue_next = issue_reg;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        addr_next  = addr_reg;
        end_next   = end_reg;
        ok_next    = ok_reg;
        data_next  = data_reg;
        fpos_next  = fpos_reg;
        mem_req    = '0;
        res_valid  = 1'b0;
        rd_issue   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_mode;
                    pos_next   = ils_pkg::IDX_W'(in_pos);
                    val_next   = in_value;
                    ok_next    = 1'b0;
                    data_next  = '0;
                    fpos_next  = '0;
                    issue_next = 1'b0;
                    state_next = ST_DONE;
                    case (in_mode)
                        ils_pkg::MODE_PUSH:
                        begin
                            if (!full)
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = ils_pkg::IDX_W'(count_reg);
                                mem_req.wr_data = in_value;
                                count_next      = count_reg + 1'b1;
                                ok_next         = 1'b1;
                            end
                        end
                        ils_pkg::MODE_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_dec;
                                ok_next    = 1'b1;
                                addr_next  = ils_pkg::IDX_W'(count_dec);
                                end_next   = ils_pkg::IDX_W'(count_dec);
                                issue_next = 1'b1;
                                state_next = ST_RUN;
                            end
                        end
                        ils_pkg::MODE_GET:
                        begin
                            if (pos_cmp < cnt_cmp)
                            begin
                                ok_next    = 1'b1;
                                addr_next  = ils_pkg::IDX_W'(in_pos);
                                end_next   = ils_pkg::IDX_W'(in_pos);
                                issue_next = 1'b1;
                                state_next = ST_RUN;
                            end
                        end
                        ils_pkg::MODE_INSERT:
                        begin
                            if ((pos_cmp <= cnt_cmp) && !full)
                            begin
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                                if (pos_cmp == cnt_cmp)
                                begin
                                    // Insert at the end acts as a push
                                    mem_req.wr_en   = 1'b1;
                                    mem_req.wr_addr = ils_pkg::IDX_W'(in_pos);
                                    mem_req.wr_data = in_value;
                                end
                                else
                                begin
                                    addr_next  = ils_pkg::IDX_W'(count_dec);
                                    end_next   = ils_pkg::IDX_W'(in_pos);
                                    issue_next = 1'b1;
                                    state_next = ST_RUN;
                                end
                            end
                        end
                        ils_pkg::MODE_DELETE:
                        begin
                            if (pos_cmp < cnt_cmp)
                            begin
                                count_next = count_dec;
                                ok_next    = 1'b1;
                                addr_next  = ils_pkg::IDX_W'(in_pos);
                                end_next   = ils_pkg::IDX_W'(count_dec);
                                issue_next = 1'b1;
                                state_next = ST_RUN;
                            end
                        end
                        ils_pkg::MODE_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                addr_next  = '0;
                                end_next   = ils_pkg::IDX_W'(count_dec);
                                issue_next = 1'b1;
                                state_next = ST_RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // Issue the next read, walking down for insert and up otherwise
                if (issue_reg)
                begin
                    rd_issue        = 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = addr_reg;
                    if (issue_last)
                    begin
                        issue_next = 1'b0;
                    end
                    else if (mode_reg == ils_pkg::MODE_INSERT)
                    begin
                        addr_next = addr_reg - 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                // Handle the word read in the previous cycle
                if (pend_reg)
                begin
                    case (mode_reg)
                        ils_pkg::MODE_POP,
                        ils_pkg::MODE_GET:
                        begin
                            data_next  = mem_rdata;
                            state_next = ST_DONE;
                        end
                        ils_pkg::MODE_INSERT:
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = paddr_reg + 1'b1;
                            mem_req.wr_data = mem_rdata;
                            if (plast_reg)
                            begin
                                state_next = ST_FINAL;
                            end
                        end
                        ils_pkg::MODE_DELETE:
                        begin
                            if (paddr_reg == pos_reg)
                            begin
                                data_next = mem_rdata;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = paddr_reg - 1'b1;
                                mem_req.wr_data = mem_rdata;
                            end
                            if (plast_reg)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        ils_pkg::MODE_FIND:
                        begin
                            if (mem_rdata == val_reg)
                            begin
                                ok_next    = 1'b1;
                                fpos_next  = paddr_reg;
                                issue_next = 1'b0;
                                state_next = ST_DONE;
                            end
                            else if (plast_reg)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FINAL:
            begin
                // Place the new word once the shift is complete
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                mem_req.wr_data = val_reg;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the read in flight
    assign pend_next  = rd_issue && (state_next == ST_RUN);
    assign paddr_next = addr_reg;
    assign plast_next = issue_last;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    // Hold operation and result payload
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        addr_reg  <= addr_next;
        end_reg   <= end_next;
        paddr_reg <= paddr_next;
        plast_reg <= plast_next;
        ok_reg    <= ok_next;
        data_reg  <= data_next;
        fpos_reg  <= fpos_next;
    end

    assign res.ok    = ok_reg;
    assign res.data  = data_reg;
    assign res.fpos  = ils_pkg::FPOS_W'(fpos_reg);
    assign res.count = ils_pkg::COUNT_OUT_W'(count_reg);

endmodule

`default_nettype wire

### design/indexed_list_store.sv
`default_nettype none

// Ordered list of 32-bit words held in a single-port-write, single-port-read
// memory of MAX_ELEMENTS entries. Each item on the s_ group names one
// operation (push, pop, get, insert, delete, find) and gives exactly one
// result item on the m_ group, carrying ok, the data word, the found
// position and the element count after the operation.
// Items are handled one at a time. Push and insert at the end write one
// entry directly; pop and get read one entry. Insert, delete and find walk
// the element memory, at most one read and one write per cycle, so their
// time grows with the entries moved or searched; find stops at its first
// match. s_tready rises again as the result enters the output register.
// Reset clears the element count; memory contents need no clearing since
// only entries below the count are ever read. While m_tready is low the
// result holds in the output register, one more result may finish behind
// it, and the input stays stalled until that one moves on.

module indexed_list_store (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,    // position_in[6:0], value_in[38:7], zero pad
    input  wire  [2:0]  s_tuser,    // mode[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,    // data_out[31:0], found_position[37:32],
                                    // count_after[44:38], zero pad
    output logic [0:0]  m_tuser     // ok[0]
);

    ils_pkg::mem_req_t           mem_req;
    logic [ils_pkg::DATA_W-1:0]  mem_rdata;
    logic                        res_valid;
    logic                        res_ready;
    ils_pkg::res_t               res;
    ils_pkg::res_t               out_reg;
    logic                        out_valid_reg;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_pos    (s_tdata[6:0]),
        .in_value  (s_tdata[38:7]),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ils_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result item when the register is free
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.count, out_reg.fpos, out_reg.data};
    assign m_tuser  = out_reg.ok;

    // An accepted item keeps the input closed for the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an operation is in progress");

    // A failed operation carries a zero data word
    a_err_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
        else $error("error result with nonzero data");

    // The count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(out_reg.count) <= 32'(ils_pkg::MAX_ELEMENTS)))
        else $error("element count above capacity");

endmodule

`default_nettype wire

### verif/tb_indexed_list_store.sv
`default_nettype none

module tb_indexed_list_store;
    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    // Mode codes the block does not define; it must answer them with ok=0
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 450;
    localparam int TAIL_CYCLES   = 100;
    localparam int LIMIT_NS      = 5_000_000;

    // One request on the input side
    typedef struct {
        logic [MODE_W-1:0] op;
        logic [POS_W-1:0]  idx;
        logic [DATA_W-1:0] word;
        bit                drain;   // wait until all results are back first
    } list_req_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;     // position_in[6:0], value_in[38:7], zero pad
    logic [2:0]  s_tuser  = '0;     // mode[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // data_out[31:0], found_position[37:32],
                                    // count_after[44:38], zero pad
    logic [0:0]  m_tuser;           // ok[0]

    indexed_list_store u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    list_req_t   pending_items[$];
    res_t        predicted_results[$];
    list_req_t   req;
    res_t        got;
    res_t        want;

    // Shadow copy of the list
    logic [DATA_W-1:0] shadow_list [MAX_ELEMENTS];
    int          shadow_len = 0;

    int          n_sent = 0;
    int          n_recv = 0;
    int          n_total = 0;
    int          n_errors = 0;
    int          gen_len = 0;

    // Coverage tallies for the summary
    int          n_ok = 0;
    int          n_rejected = 0;
    int          n_full_refused = 0;
    int          n_find_hits = 0;
    int          peak_len = 0;

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one operation to the shadow list and return the result it gives
    function automatic res_t list_apply(logic [MODE_W-1:0] op, logic [POS_W-1:0] idx,
                                        logic [DATA_W-1:0] word);
        res_t r;
        int   i;
        r = '0;
        case (op)
            MODE_PUSH:
                if (shadow_len < MAX_ELEMENTS)
                begin
                    shadow_list[IDX_W'(shadow_len)] = word;
                    shadow_len++;
                    r.ok = 1'b1;
                end
            MODE_POP:
                if (shadow_len > 0)
                begin
                    shadow_len--;
                    r.data = shadow_list[IDX_W'(shadow_len)];
                    r.ok   = 1'b1;
                end
            MODE_GET:
                if (idx < shadow_len)
                begin
                    r.data = shadow_list[IDX_W'(idx)];
                    r.ok   = 1'b1;
                end
            MODE_INSERT:
                if (idx <= shadow_len && shadow_len < MAX_ELEMENTS)
                begin
                    for (i = shadow_len; i > idx; i--)
                        shadow_list[IDX_W'(i)] = shadow_list[IDX_W'(i-1)];
                    shadow_list[IDX_W'(idx)] = word;
                    shadow_len++;
                    r.ok = 1'b1;
                end
            MODE_DELETE:
                if (idx < shadow_len)
                begin
                    r.data = shadow_list[IDX_W'(idx)];
                    for (i = idx; i + 1 < shadow_len; i++)
                        shadow_list[IDX_W'(i)] = shadow_list[IDX_W'(i+1)];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            MODE_FIND:
                for (i = 0; i < shadow_len && !r.ok; i++)
                begin
                    if (shadow_list[IDX_W'(i)] == word)
                    begin
                        r.ok   = 1'b1;
                        r.fpos = i[FPOS_W-1:0];
                    end
                end
            default: ;
        endcase
        r.count = shadow_len[COUNT_OUT_W-1:0];

        // tally what was exercised
        if (r.ok)
            n_ok++;
        else
            n_rejected++;
        if ((op == MODE_PUSH || op == MODE_INSERT) && !r.ok && shadow_len == MAX_ELEMENTS)
            n_full_refused++;
        if (op == MODE_FIND && r.ok)
            n_find_hits++;
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        return r;
    endfunction

    // Idle rates: sender light and receiver heavy, then swapped, then none
    function automatic int sender_idle_pct(int done);
        if (done * 3 < n_total)
            return 16;
        else if (done * 3 < n_total * 2)
            return 60;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int done);
        if (done * 3 < n_total)
            return 60;
        else if (done * 3 < n_total * 2)
            return 16;
        return 0;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Queue one request and track the list length it leaves behind
    task automatic queue_item(logic [MODE_W-1:0] op, int idx, logic [DATA_W-1:0] word,
                              bit drain);
        list_req_t it;
        it.op    = op;
        it.idx   = idx[POS_W-1:0];
        it.word  = word;
        it.drain = drain;
        pending_items.push_back(it);
        case (op)
            MODE_PUSH:   if (gen_len < MAX_ELEMENTS) gen_len++;
            MODE_POP:    if (gen_len > 0) gen_len--;
            MODE_INSERT: if (idx <= gen_len && gen_len < MAX_ELEMENTS) gen_len++;
            MODE_DELETE: if (idx < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    // Pick a word: mostly from a small pool so finds hit, sometimes anything
    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom_range(15);
        else if (r < 50)
            return 32'h8000_0000;
        else if (r < 55)
            return 32'h7FFF_FFFF;
        else if (r < 60)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // Driver: offer pending items, predict each one at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            n_sent   <= 0;
        end
        else
        begin
            // record what the accepted item should produce
            if (s_tvalid && s_tready)
            begin
                predicted_results.push_back(list_apply(s_tuser, s_tdata[6:0],
                                                       s_tdata[38:7]));
                n_sent <= n_sent + 1;
            end
            // offer the next item, or hold back
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0
                    && !(pending_items[0].drain
                         && n_recv != n_sent + (s_tvalid && s_tready))
                    && $urandom_range(99) >= sender_idle_pct(n_sent))
                begin
                    req = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req.op;
                    s_tdata  <= {1'b0, req.word, req.idx};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            n_recv   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.ok    = m_tuser[0];
                got.data  = m_tdata[31:0];
                got.fpos  = m_tdata[37:32];
                got.count = m_tdata[44:38];
                if (n_recv >= n_sent)
                begin
                    report_mismatch($sformatf("result #%0d with no item outstanding", n_recv));
                end
                else
                begin
                    want = predicted_results[n_recv];
                    if (got.ok !== want.ok)
                        report_mismatch($sformatf("result #%0d ok %b, want %b",
                                                  n_recv, got.ok, want.ok));
                    if (got.data !== want.data)
                        report_mismatch($sformatf("result #%0d data_out %h, want %h",
                                                  n_recv, got.data, want.data));
                    if (got.fpos !== want.fpos)
                        report_mismatch($sformatf("result #%0d found_position %0d, want %0d",
                                                  n_recv, got.fpos, want.fpos));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("result #%0d count_after %0d, want %0d",
                                                  n_recv, got.count, want.count));
                end
                n_recv <= n_recv + 1;
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct(n_sent));
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int  k;
        int  r;
        int  idx;
        bit  growing;
        logic [MODE_W-1:0] op;

        // empty-list errors
        queue_item(MODE_POP,    0, 32'h0, 1'b0);
        queue_item(MODE_FIND,   0, 32'h0, 1'b0);
        queue_item(MODE_GET,    0, 32'h0, 1'b0);
        queue_item(MODE_DELETE, 0, 32'h0, 1'b0);
        queue_item(MODE_INSERT, 1, 32'h1234_5678, 1'b0);
        // insert at the count acts as a push; extreme words
        queue_item(MODE_INSERT, 0, 32'h8000_0000, 1'b0);
        queue_item(MODE_PUSH,   0, 32'h7FFF_FFFF, 1'b0);
        queue_item(MODE_PUSH,   0, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_PUSH,   0, 32'h0000_0000, 1'b0);
        // insert in the middle and at the front
        queue_item(MODE_INSERT, 2, 32'h0000_0005, 1'b0);
        queue_item(MODE_INSERT, 0, 32'h0000_0005, 1'b0);
        // reads in range, at the count and far past it
        queue_item(MODE_GET,    0, 32'h0, 1'b0);
        queue_item(MODE_GET,    5, 32'h0, 1'b0);
        queue_item(MODE_GET,    6, 32'h0, 1'b0);
        queue_item(MODE_GET,   64, 32'h0, 1'b0);
        // find: duplicate picks the lowest index, then a single hit, then a miss
        queue_item(MODE_FIND,   0, 32'h0000_0005, 1'b0);
        queue_item(MODE_FIND,   0, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_FIND,   0, 32'h0000_3039, 1'b0);
        // delete in the middle, at the end, past the end; insert past the count
        queue_item(MODE_DELETE, 1, 32'h0, 1'b1);
        queue_item(MODE_DELETE, 4, 32'h0, 1'b0);
        queue_item(MODE_DELETE, 4, 32'h0, 1'b0);
        queue_item(MODE_INSERT, 64, 32'h0, 1'b0);
        // undefined modes
        queue_item(MODE_SPARE_LO, 64, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_SPARE_HI, 127, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_POP,    0, 32'h0, 1'b0);

        // random part: swing the list between empty and full
        growing = 1'b1;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (gen_len == MAX_ELEMENTS && $urandom_range(3) == 0)
                growing = 1'b0;
            else if (gen_len == 0 && $urandom_range(3) == 0)
                growing = 1'b1;
            r = $urandom_range(99);
            if (r < 3)
                op = MODE_W'($urandom_range(7, 6));
            else if (r < 15)
                op = MODE_GET;
            else if (r < 27)
                op = MODE_FIND;
            else if ($urandom_range(99) < (growing ? 75 : 25))
                op = $urandom_range(1) ? MODE_PUSH : MODE_INSERT;
            else
                op = $urandom_range(1) ? MODE_POP : MODE_DELETE;
            if ($urandom_range(99) < 80)
                idx = $urandom_range(gen_len);
            else
                idx = $urandom_range(MAX_ELEMENTS);
            queue_item(op, idx, pick_word(), (k % 150) == 149);
        end
        n_total = pending_items.size();

        // reset
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all items out and all results back
        @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || n_recv != n_sent)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (n_recv != n_sent)
            report_mismatch($sformatf("%0d results never arrived", n_sent - n_recv));

        $display("Ran %0d list operations: %0d succeeded, %0d rejected, %0d finds hit.",
                 n_sent, n_ok, n_rejected, n_find_hits);
        $display("Longest list %0d of %0d; %0d pushes or inserts refused while full.",
                 peak_len, MAX_ELEMENTS, n_full_refused);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("Timeout with %0d of %0d results received", n_recv, n_total);
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### indexed_list_store.f
design/ils_pkg.sv
design/ils_ram.sv
design/ils_ctrl.sv
design/indexed_list_store.sv
verif/tb_indexed_list_store.sv
